@@ sv/bgr_pkg.sv @@
package bgr_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ACT_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP    = 2'd2;

  localparam logic [CFG_W-1:0] LONG_HOLD_RESET     = 16'd1000;
  localparam logic [CFG_W-1:0] RESERVED_HOLD_RESET = 16'd5000;
  localparam logic [CFG_W-1:0] DOUBLE_TAP_RESET    = 16'd400;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE     = 3'd0,
    ACT_CYCLE    = 3'd1,
    ACT_RESERVED = 3'd2,
    ACT_PRESET   = 3'd3,
    ACT_WAKE     = 3'd4
  } action_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_hold_ms;
    logic [CFG_W-1:0] reserved_hold_ms;
    logic [CFG_W-1:0] double_tap_ms;
  } cfg_t;

endpackage

@@ sv/bgr_ifs.sv @@
interface bgr_sample_if;
  logic                       valid;
  logic                       ready;
  logic                       button_down;
  logic [bgr_pkg::TIME_W-1:0] time_ms;

  modport source (output valid, output button_down, output time_ms, input ready);
  modport sink   (input valid, input button_down, input time_ms, output ready);
endinterface

interface bgr_result_if;
  logic                      valid;
  logic                      ready;
  logic [bgr_pkg::ACT_W-1:0] action;

  modport source (output valid, output action, input ready);
  modport sink   (input valid, input action, output ready);
endinterface

@@ sv/bgr_cfg_regs.sv @@
module bgr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgr_pkg::CFG_W-1:0]     cfg_data,
  output bgr_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_hold_ms     <= bgr_pkg::LONG_HOLD_RESET;
      cfg.reserved_hold_ms <= bgr_pkg::RESERVED_HOLD_RESET;
      cfg.double_tap_ms    <= bgr_pkg::DOUBLE_TAP_RESET;
    end else if (cfg_we) begin
      // writes to an unused index are dropped
      unique case (cfg_index)
        bgr_pkg::REG_LONG_HOLD:     cfg.long_hold_ms     <= cfg_data;
        bgr_pkg::REG_RESERVED_HOLD: cfg.reserved_hold_ms <= cfg_data;
        bgr_pkg::REG_DOUBLE_TAP:    cfg.double_tap_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/bgr_core.sv @@
module bgr_core (
  input  logic                       clk,
  input  logic                       rst,
  input  bgr_pkg::cfg_t              cfg,
  input  logic                       step,
  input  logic                       button_down,
  input  logic [bgr_pkg::TIME_W-1:0] time_ms,
  output bgr_pkg::action_t           action
);

  localparam int PAD_W = bgr_pkg::TIME_W - bgr_pkg::CFG_W;

  logic                       is_down, is_down_next;
  logic [bgr_pkg::TIME_W-1:0] press_time, press_time_next;
  logic [bgr_pkg::TIME_W-1:0] first_release_time, first_release_time_next;
  logic                       tap_waiting, tap_waiting_next;
  logic                       long_fired, long_fired_next;
  logic                       reserved_fired, reserved_fired_next;

  logic [bgr_pkg::TIME_W-1:0] held;
  logic [bgr_pkg::TIME_W-1:0] gap;
  logic [bgr_pkg::TIME_W-1:0] long_lim, reserved_lim, tap_lim;

  // differences wrap mod 2^32, so a step back in time reads as very long
  assign held         = time_ms - press_time;
  assign gap          = time_ms - first_release_time;
  assign long_lim     = {{PAD_W{1'b0}}, cfg.long_hold_ms};
  assign reserved_lim = {{PAD_W{1'b0}}, cfg.reserved_hold_ms};
  assign tap_lim      = {{PAD_W{1'b0}}, cfg.double_tap_ms};

  always_comb begin
    is_down_next            = is_down;
    press_time_next         = press_time;
    first_release_time_next = first_release_time;
    tap_waiting_next        = tap_waiting;
    long_fired_next         = long_fired;
    reserved_fired_next     = reserved_fired;
    action                  = bgr_pkg::ACT_NONE;
    if (button_down && !is_down) begin
      is_down_next        = 1'b1;
      press_time_next     = time_ms;
      long_fired_next     = 1'b0;
      reserved_fired_next = 1'b0;
    end else if (button_down) begin
      // long hold wins; reserved follows on a later held item
      if (!long_fired && held >= long_lim) begin
        long_fired_next  = 1'b1;
        tap_waiting_next = 1'b0;
        action           = bgr_pkg::ACT_CYCLE;
      end else if (!reserved_fired && held >= reserved_lim) begin
        reserved_fired_next = 1'b1;
        tap_waiting_next    = 1'b0;
        action              = bgr_pkg::ACT_RESERVED;
      end
    end else if (is_down) begin
      is_down_next = 1'b0;
      if (long_fired || reserved_fired) begin
        long_fired_next     = 1'b0;
        reserved_fired_next = 1'b0;
      end else if (tap_waiting && gap <= tap_lim) begin
        tap_waiting_next = 1'b0;
        action           = bgr_pkg::ACT_PRESET;
      end else begin
        tap_waiting_next        = 1'b1;
        first_release_time_next = time_ms;
      end
    end else if (tap_waiting && gap > tap_lim) begin
      tap_waiting_next = 1'b0;
      action           = bgr_pkg::ACT_WAKE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_down            <= 1'b0;
      press_time         <= '0;
      first_release_time <= '0;
      tap_waiting        <= 1'b0;
      long_fired         <= 1'b0;
      reserved_fired     <= 1'b0;
    end else if (step) begin
      is_down            <= is_down_next;
      press_time         <= press_time_next;
      first_release_time <= first_release_time_next;
      tap_waiting        <= tap_waiting_next;
      long_fired         <= long_fired_next;
      reserved_fired     <= reserved_fired_next;
    end
  end

endmodule

@@ sv/button_gesture_recognizer.sv @@
// Button gesture recognizer: turns a stream of (button level, ms timestamp)
// samples into one action code per sample: none, cycle display (held at least
// long_hold_ms), reserved (held at least reserved_hold_ms), cycle preset
// (double tap) or wake display (lone tap once the double-tap window has run
// out). The block takes one sample every cycle unless a finished action is
// held waiting. A sample is registered in the staging register on accept,
// decided by 32-bit subtracts and compares against the gesture state, and its
// action lands in the result register, so a new sample can be staged while a
// finished action waits. The user must write the configuration through
// cfg_we/cfg_index/cfg_data only while no sample is in flight; unchecked here.
module button_gesture_recognizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgr_pkg::CFG_W-1:0]     cfg_data,
  bgr_sample_if.sink                    sample,
  bgr_result_if.source                  result
);

  bgr_pkg::cfg_t              cfg;
  bgr_pkg::action_t           action;

  logic                       stg_valid;
  logic                       stg_down;
  logic [bgr_pkg::TIME_W-1:0] stg_time;
  logic                       res_valid;
  logic [bgr_pkg::ACT_W-1:0]  res_action;
  logic                       advance;

  assign advance      = stg_valid && (!res_valid || result.ready);
  assign sample.ready = !stg_valid || advance;
  assign result.valid = res_valid;
  assign result.action = res_action;

  bgr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (advance),
    .button_down (stg_down),
    .time_ms     (stg_time),
    .action      (action)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (sample.ready) begin
      stg_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      stg_down <= sample.button_down;
      stg_time <= sample.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_action <= action;
    end
  end

endmodule
